@@ rtl/ctc_greedy_label_decoder_assert.svh @@
// Assertion macros shared by the checker of the CTC greedy label decoder.
// Include with the bare file name; no other dependencies.
`ifndef CTC_GREEDY_LABEL_DECODER_ASSERT_SVH
`define CTC_GREEDY_LABEL_DECODER_ASSERT_SVH

// Property checked on every rising edge, skipped while reset is held.
`define CGLD_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define CGLD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ctc_gld_pkg.sv @@
// Shared types and constants of the CTC greedy label decoder.
// No dependencies; imported by every module of the block.
package ctc_gld_pkg;

    localparam int NUM_CLASSES_DEF = 76;
    localparam int MAX_CHARS_DEF   = 16;
    localparam int SCORE_WIDTH_DEF = 16;

    localparam int LABEL_W = 7;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    localparam logic [LABEL_W-1:0] LABEL_BLANK = 7'd0;
    localparam logic [LABEL_W-1:0] LABEL_SPACE = 7'd1;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue: room for two words is needed before a word is taken.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic               found;
        logic [LABEL_W-1:0] label;
    } row_win_t;

    typedef struct packed {
        logic               kind;
        logic [LABEL_W-1:0] label;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               last;
    } res_meta_t;

endpackage

@@ rtl/ctc_greedy_label_decoder.sv @@
// CTC greedy label decoder.
// Input stream: one class score per word in s_tdata, classes of a row in
// index order; s_tlast marks the last score of a row, s_tuser (with
// s_tlast) marks the last row of a frame.
// Output stream: m_tuser low is a character word (label, row maximum,
// slot, count so far); m_tuser high is the end-of-frame summary (count,
// overflow flag). m_tlast marks the last word caused by one input word.
// Throughput: one input word per clock while s_tready is high. The row
// max/argmax update and the collapse decision are combinational from the
// accepted word into a four-word result queue, so a result word is queued,
// with m_tvalid high, in the cycle after the row-end word is taken. A frame-end
// row with a character gives two words, one per cycle while m_tready is high.
// s_tready is high while the queue has room for two words; when the
// receiver stalls the queue fills and s_tready drops, and no word is lost.
// Reset (aresetn low, synchronous) clears the row maximum, the repeat
// history, the character count and empties the queue.
// Depends on ctc_gld_pkg, ctc_gld_row_max, ctc_gld_collapse, ctc_gld_out_queue.
module ctc_greedy_label_decoder #(
    parameter int NUM_CLASSES = ctc_gld_pkg::NUM_CLASSES_DEF,
    parameter int MAX_CHARS   = ctc_gld_pkg::MAX_CHARS_DEF,
    parameter int SCORE_WIDTH = ctc_gld_pkg::SCORE_WIDTH_DEF,
    localparam int S_TDATA_W  = ((SCORE_WIDTH + 7) / 8) * 8,
    localparam int M_FIELDS_W = ctc_gld_pkg::LABEL_W + SCORE_WIDTH
                                + ctc_gld_pkg::POS_W + ctc_gld_pkg::COUNT_W + 1,
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // class_score
    input  logic                 s_tlast,  // row_end
    input  logic                 s_tuser,  // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // label_index, label_score, position,
                                           // char_count, overflow
    output logic                 m_tlast,  // last
    output logic                 m_tuser   // kind
);
    import ctc_gld_pkg::*;

    logic                          accept;
    logic signed [SCORE_WIDTH-1:0] score;
    row_win_t                      win;
    logic signed [SCORE_WIDTH-1:0] win_score;
    logic                          char_valid, sum_valid, room, out_valid;
    res_meta_t                     char_meta, sum_meta, out_meta;
    logic signed [SCORE_WIDTH-1:0] out_score;

    assign score    = s_tdata[SCORE_WIDTH-1:0];
    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ctc_gld_row_max #(
        .NUM_CLASSES(NUM_CLASSES),
        .SCORE_WIDTH(SCORE_WIDTH)
    ) u_row_max (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .score    (score),
        .row_end  (s_tlast),
        .win      (win),
        .win_score(win_score)
    );

    ctc_gld_collapse #(
        .MAX_CHARS(MAX_CHARS)
    ) u_collapse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .row_end   (s_tlast),
        .frame_end (s_tuser),
        .win       (win),
        .char_valid(char_valid),
        .char_meta (char_meta),
        .sum_valid (sum_valid),
        .sum_meta  (sum_meta)
    );

    ctc_gld_out_queue #(
        .SCORE_WIDTH(SCORE_WIDTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_valid(char_valid),
        .char_meta (char_meta),
        .char_score(win_score),
        .sum_valid (sum_valid),
        .sum_meta  (sum_meta),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (m_tready),
        .out_meta  (out_meta),
        .out_score (out_score)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'({out_meta.overflow, out_meta.count, out_meta.position,
                                  out_score, out_meta.label});
    assign m_tlast  = out_meta.last;
    assign m_tuser  = out_meta.kind;

endmodule

@@ rtl/ctc_gld_row_max.sv @@
// Running strict maximum, from zero, and argmax over the class scores
// of one row; a tie keeps the lower class. Depends on ctc_gld_pkg.
module ctc_gld_row_max #(
    parameter int NUM_CLASSES = ctc_gld_pkg::NUM_CLASSES_DEF,
    parameter int SCORE_WIDTH = ctc_gld_pkg::SCORE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic signed [SCORE_WIDTH-1:0] score,
    input  logic                          row_end,
    output ctc_gld_pkg::row_win_t         win,
    output logic signed [SCORE_WIDTH-1:0] win_score
);
    import ctc_gld_pkg::*;

    localparam int CNT_W = $clog2(NUM_CLASSES + 1);

    logic signed [SCORE_WIDTH-1:0] max_reg, max_next, upd_max;
    logic [LABEL_W-1:0]            label_reg, label_next, upd_label;
    logic                          found_reg, found_next, upd_found;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          take, better;

    always_comb begin
        take      = (cnt_reg < CNT_W'(NUM_CLASSES));
        better    = take && (max_reg < score);
        upd_max   = better ? score : max_reg;
        upd_label = better ? LABEL_W'(cnt_reg) : label_reg;
        upd_found = found_reg | better;

        max_next   = max_reg;
        label_next = label_reg;
        found_next = found_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            if (row_end) begin
                max_next   = '0;
                label_next = '0;
                found_next = 1'b0;
                cnt_next   = '0;
            end else begin
                max_next   = upd_max;
                label_next = upd_label;
                found_next = upd_found;
                cnt_next   = take ? cnt_reg + CNT_W'(1) : cnt_reg;
            end
        end
    end

    assign win.found = upd_found;
    assign win.label = upd_label;
    assign win_score = upd_max;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= '0;
            label_reg <= '0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            max_reg   <= max_next;
            label_reg <= label_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/ctc_gld_collapse.sv @@
// Greedy CTC collapse: drops blank, space and repeats, counts characters
// and builds the character and end-of-frame words. Depends on ctc_gld_pkg.
module ctc_gld_collapse #(
    parameter int MAX_CHARS = ctc_gld_pkg::MAX_CHARS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   row_end,
    input  logic                   frame_end,
    input  ctc_gld_pkg::row_win_t  win,
    output logic                   char_valid,
    output ctc_gld_pkg::res_meta_t char_meta,
    output logic                   sum_valid,
    output ctc_gld_pkg::res_meta_t sum_meta
);
    import ctc_gld_pkg::*;

    logic [COUNT_W-1:0] kept_reg, kept_next, kept_after;
    logic               ovf_reg, ovf_next, ovf_after;
    logic [LABEL_W-1:0] prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic               row_done, is_repeat, is_char, room;

    always_comb begin
        row_done   = accept && row_end;
        is_repeat  = prev_valid_reg && (prev_reg == win.label);
        is_char    = row_done && win.found && (win.label != LABEL_BLANK)
                     && (win.label != LABEL_SPACE) && !is_repeat;
        room       = (kept_reg < COUNT_W'(MAX_CHARS));
        char_valid = is_char && room;
        sum_valid  = row_done && frame_end;
        kept_after = char_valid ? kept_reg + COUNT_W'(1) : kept_reg;
        ovf_after  = ovf_reg || (is_char && !room);

        char_meta.kind     = KIND_CHAR;
        char_meta.label    = win.label;
        char_meta.position = POS_W'(kept_reg);
        char_meta.count    = kept_after;
        char_meta.overflow = 1'b0;
        char_meta.last     = !frame_end;

        sum_meta.kind      = KIND_SUMMARY;
        sum_meta.label     = '0;
        sum_meta.position  = '0;
        sum_meta.count     = kept_after;
        sum_meta.overflow  = ovf_after;
        sum_meta.last      = 1'b1;

        kept_next       = kept_reg;
        ovf_next        = ovf_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        if (sum_valid) begin
            // frame done: back to a clean frame
            kept_next       = '0;
            ovf_next        = 1'b0;
            prev_next       = '0;
            prev_valid_next = 1'b0;
        end else if (row_done) begin
            kept_next = kept_after;
            ovf_next  = ovf_after;
            if (win.found) begin
                prev_next       = win.label;
                prev_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg       <= '0;
            ovf_reg        <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end else begin
            kept_reg       <= kept_next;
            ovf_reg        <= ovf_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

endmodule

@@ rtl/ctc_gld_out_queue.sv @@
// Result queue: takes up to two words a cycle, hands out one word a cycle
// while out_ready is high. Depends on ctc_gld_pkg.
module ctc_gld_out_queue #(
    parameter int SCORE_WIDTH = ctc_gld_pkg::SCORE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          char_valid,
    input  ctc_gld_pkg::res_meta_t        char_meta,
    input  logic signed [SCORE_WIDTH-1:0] char_score,
    input  logic                          sum_valid,
    input  ctc_gld_pkg::res_meta_t        sum_meta,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ctc_gld_pkg::res_meta_t        out_meta,
    output logic signed [SCORE_WIDTH-1:0] out_score
);
    import ctc_gld_pkg::*;

    res_meta_t                     meta_mem  [QUEUE_DEPTH];
    logic signed [SCORE_WIDTH-1:0] score_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, sum_addr;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        n_push;
    logic              pop;

    always_comb begin
        n_push      = {1'b0, char_valid} + {1'b0, sum_valid};
        pop         = out_valid && out_ready;
        cnt_next    = cnt_reg + QCNT_W'(n_push) - QCNT_W'(pop);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        sum_addr    = char_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    end

    assign room      = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_meta  = meta_mem[rd_ptr_reg];
    assign out_score = score_mem[rd_ptr_reg];

    // character word goes in ahead of the summary of the same row
    always_ff @(posedge aclk) begin
        if (char_valid) begin
            meta_mem[wr_ptr_reg]  <= char_meta;
            score_mem[wr_ptr_reg] <= char_score;
        end
        if (sum_valid) begin
            meta_mem[sum_addr]  <= sum_meta;
            score_mem[sum_addr] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/ctc_gld_checker.sv @@
// Port-level checker of the CTC greedy label decoder, bound to the top level.
// Depends on ctc_gld_pkg and ctc_greedy_label_decoder_assert.svh.
`include "ctc_greedy_label_decoder_assert.svh"

module ctc_gld_checker #(
    parameter int MAX_CHARS   = ctc_gld_pkg::MAX_CHARS_DEF,
    parameter int SCORE_WIDTH = ctc_gld_pkg::SCORE_WIDTH_DEF,
    parameter int M_TDATA_W   = 40
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);
    import ctc_gld_pkg::*;

    localparam int CNT_LO  = LABEL_W + SCORE_WIDTH + POS_W;
    localparam int OVF_BIT = CNT_LO + COUNT_W;

    logic [LABEL_W-1:0] lbl;
    logic [COUNT_W-1:0] cnt;
    logic               ovf;

    assign lbl = m_tdata[LABEL_W-1:0];
    assign cnt = m_tdata[CNT_LO +: COUNT_W];
    assign ovf = m_tdata[OVF_BIT];

    `CGLD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "word shown after reset")
    `CGLD_ASSERT_RST(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled word changed")
    `CGLD_ASSERT_RST(a_char_word, aclk, aresetn, m_tvalid && (m_tuser == KIND_CHAR) |-> (lbl != LABEL_BLANK) && (lbl != LABEL_SPACE) && !ovf && (cnt != '0) && (cnt <= COUNT_W'(MAX_CHARS)), "bad character word")
    `CGLD_ASSERT_RST(a_summary_word, aclk, aresetn, m_tvalid && (m_tuser == KIND_SUMMARY) |-> m_tlast && (lbl == '0) && (cnt <= COUNT_W'(MAX_CHARS)), "bad summary word")

endmodule

bind ctc_greedy_label_decoder ctc_gld_checker #(
    .MAX_CHARS  (MAX_CHARS),
    .SCORE_WIDTH(SCORE_WIDTH),
    .M_TDATA_W  (M_TDATA_W)
) u_ctc_gld_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);
